// ===== rtl/mssm_pkg.sv =====
`timescale 1ns / 1ps
package mssm_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_CLOSE   = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_DROP   = 2'd2
  } kind_e;

  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  localparam int unsigned REQ_BITS  = 2;
  localparam int unsigned SID_BITS  = 3;
  localparam int unsigned WIN_BITS  = 32;
  localparam int unsigned KIND_BITS = 2;
  localparam int unsigned WOUT_BITS = 32;
  localparam int unsigned EN_BITS   = 8;

  typedef struct packed {
    logic apply;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic       drop;
    logic       done;
    logic       stall;
    logic       finished;
    logic       emit;
  } stat_t;

endpackage

// ===== rtl/mssm_datapath.sv =====
`timescale 1ns / 1ps
module mssm_datapath #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mssm_pkg::REQ_BITS-1:0] req_i,
  input  logic [mssm_pkg::SID_BITS-1:0] sid_i,
  input  logic [mssm_pkg::WIN_BITS-1:0] word_i,
  input  logic [1:0]                    mode_i,
  input  logic [mssm_pkg::EN_BITS-1:0]  enable_i,
  input  mssm_pkg::cmd_t                cmd_i,
  output mssm_pkg::stat_t               stat_o,
  output logic [WORD_BITS-1:0]          min_o
);
  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SB = mssm_pkg::SID_BITS;

  logic [WORD_BITS-1:0] mem_q [NUM_STREAMS][QUEUE_DEPTH];
  logic [PW-1:0] rp_q [NUM_STREAMS];
  logic [FW-1:0] fill_q [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] closed_q;
  logic finished_q;

  logic [NUM_STREAMS-1:0] en, empty, exh, active, first, has_min;
  logic [WORD_BITS-1:0] heads [NUM_STREAMS];
  logic [WORD_BITS-1:0] mn;
  logic have, done, sid_ok;
  logic [PW-1:0] slot;
  logic [FW:0] slot_sum;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(1);
    if (s >= (PW+1)'(QUEUE_DEPTH)) s = '0;
    return s[PW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_STREAMS; i++) begin
      en[i]    = (i < mssm_pkg::EN_BITS) ? enable_i[i] : 1'b0;
      empty[i] = (fill_q[i] == '0);
      heads[i] = (QUEUE_DEPTH > 1) ? mem_q[i][rp_q[i]] : mem_q[i][0];
    end
    exh    = en & closed_q & empty;
    active = en & ~exh;
    first  = en & (~en + NUM_STREAMS'(1));
    unique case (mode_i)
      mssm_pkg::MODE_INTER: done = (active == '0) || (active != en);
      mssm_pkg::MODE_DIFF:  done = (first == '0) || ((exh & first) != '0);
      default:              done = (active == '0);
    endcase
    have = 1'b0;
    mn = '0;
    has_min = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (active[i]) begin
        if (!have || heads[i] < mn) begin
          have = 1'b1;
          mn = heads[i];
          has_min = '0;
          has_min[i] = 1'b1;
        end else if (heads[i] == mn) begin
          has_min[i] = 1'b1;
        end
      end
    end
    sid_ok = (32'(sid_i) < NUM_STREAMS);
    slot_sum = (FW+1)'(rp_q[sid_i[SB-1:0]]) + (FW+1)'(fill_q[sid_i[SB-1:0]]);
    if (slot_sum >= (FW+1)'(QUEUE_DEPTH)) slot_sum = slot_sum - (FW+1)'(QUEUE_DEPTH);
    slot = sid_ok ? PW'(slot_sum) : '0;
  end

  always_comb begin
    stat_o.finished = finished_q;
    stat_o.done     = done;
    stat_o.stall    = (active & ~closed_q & empty) != '0;
    stat_o.drop     = (req_i == mssm_pkg::REQ_PUSH) && sid_ok && !closed_q[sid_i]
                      && (32'(fill_q[sid_i]) >= QUEUE_DEPTH);
    unique case (mode_i)
      mssm_pkg::MODE_INTER: stat_o.emit = (has_min == en);
      mssm_pkg::MODE_DIFF:  stat_o.emit = (has_min == first);
      default:              stat_o.emit = 1'b1;
    endcase
  end

  assign min_o = mn;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && req_i == mssm_pkg::REQ_PUSH && sid_ok && !closed_q[sid_i]
        && !stat_o.drop)
      mem_q[sid_i][slot] <= word_i[WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        rp_q[i] <= '0;
        fill_q[i] <= '0;
      end
      closed_q <= '0;
      finished_q <= 1'b0;
    end else if (cmd_i.apply) begin
      unique case (req_i)
        mssm_pkg::REQ_PUSH: begin
          if (sid_ok && !closed_q[sid_i] && !stat_o.drop)
            fill_q[sid_i] <= fill_q[sid_i] + FW'(1);
        end
        mssm_pkg::REQ_CLOSE: begin
          if (sid_ok) closed_q[sid_i] <= 1'b1;
        end
        mssm_pkg::REQ_RESTART: begin
          for (int i = 0; i < NUM_STREAMS; i++) begin
            rp_q[i] <= '0;
            fill_q[i] <= '0;
          end
          closed_q <= '0;
          finished_q <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd_i.pop) begin
      if (done) finished_q <= 1'b1;
      else begin
        for (int i = 0; i < NUM_STREAMS; i++) begin
          if (has_min[i]) begin
            rp_q[i] <= wrap_inc(rp_q[i]);
            fill_q[i] <= fill_q[i] - FW'(1);
          end
        end
      end
    end
  end
endmodule

// ===== rtl/mssm_ctrl.sv =====
`timescale 1ns / 1ps
module mssm_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mssm_pkg::KIND_BITS-1:0] kind_o,
  output logic [mssm_pkg::WOUT_BITS-1:0] word_o,
  output logic                           last_o,
  output mssm_pkg::cmd_t                 cmd_o,
  input  mssm_pkg::stat_t                stat_i,
  input  logic [WORD_BITS-1:0]           min_i
);
  typedef enum logic {ST_IDLE, ST_MERGE} state_e;
  state_e state_q;
  logic ov_q, last_q, pend_q;
  logic [mssm_pkg::KIND_BITS-1:0] kind_q, pkind_q;
  logic [mssm_pkg::WOUT_BITS-1:0] word_q, pword_q;
  logic slot_free, merge_end, step_res, out_load;
  logic [mssm_pkg::KIND_BITS-1:0] new_kind;
  logic [mssm_pkg::WOUT_BITS-1:0] new_word;

  assign slot_free   = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign word_o      = word_q;
  assign last_o      = last_q;
  assign merge_end   = stat_i.finished || (stat_i.stall && !stat_i.done);

  always_comb begin
    cmd_o.apply = in_valid_i && in_ready_o;
    cmd_o.pop   = (state_q == ST_MERGE) && slot_free && !merge_end;
    step_res    = cmd_o.pop && (stat_i.done || stat_i.emit);
    new_kind    = stat_i.done ? mssm_pkg::KIND_FINISH : mssm_pkg::KIND_WORD;
    new_word    = stat_i.done ? '0 : mssm_pkg::WOUT_BITS'(min_i);
    out_load    = pend_q && (step_res
                  || ((state_q == ST_MERGE) && slot_free && merge_end));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
      last_q <= 1'b0;
      pend_q <= 1'b0;
      kind_q <= '0;
      word_q <= '0;
      pkind_q <= '0;
      pword_q <= '0;
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
        kind_q <= pkind_q;
        word_q <= pword_q;
        last_q <= merge_end;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.apply) begin
            pend_q <= stat_i.drop;
            pkind_q <= mssm_pkg::KIND_DROP;
            pword_q <= '0;
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (step_res) begin
            pend_q <= 1'b1;
            pkind_q <= new_kind;
            pword_q <= new_word;
          end else if (slot_free && merge_end) begin
            pend_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== rtl/multiway_sorted_set_merge_top.sv =====
`timescale 1ns / 1ps
// Each accepted item causes merge steps, one per minimum popped and one for
// the finish if reached; each result is held in a pending register until the
// next result or the end of the merge, so that its last flag is known.
// A new item is accepted only after the merge of the last one ends; an output
// stall holds the merge. One minimum selection over all heads per step.
// Reset: rst_ni asynchronous, active low; empties queues, reopens streams.
module multiway_sorted_set_merge_top #(
  parameter int unsigned NUM_STREAMS = 8,
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // stream_id[2:0], word_in[34:3], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // word_out
  output logic [1:0]  m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  logic [1:0] mode_q;
  logic [7:0] enable_q;
  mssm_pkg::cmd_t cmd;
  mssm_pkg::stat_t stat;
  logic [WORD_BITS-1:0] min_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mssm_pkg::MODE_UNION;
      enable_q <= 8'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mssm_pkg::CFG_MODE) mode_q <= cfg_data_i[1:0];
      else enable_q <= cfg_data_i;
    end
  end

  mssm_datapath #(
    .NUM_STREAMS(NUM_STREAMS), .QUEUE_DEPTH(QUEUE_DEPTH), .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .req_i(s_axis_tuser), .sid_i(s_axis_tdata[2:0]), .word_i(s_axis_tdata[34:3]),
    .mode_i(mode_q), .enable_i(enable_q),
    .cmd_i(cmd), .stat_o(stat), .min_o(min_w)
  );

  mssm_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .word_o(m_axis_tdata), .last_o(m_axis_tlast),
    .cmd_o(cmd), .stat_i(stat), .min_i(min_w)
  );

`ifndef SYNTHESIS
  a_word_kind_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != mssm_pkg::KIND_WORD |-> m_axis_tdata == '0)
    else $error("non-word result carries data");
  a_no_apply_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.apply && cmd.pop)) else $error("apply and pop together");
`endif
endmodule

// ===== tb/multiway_sorted_set_merge_top_test.sv =====
`timescale 1ns / 1ps
module multiway_sorted_set_merge_top_test;

  localparam int NSTR = 8;
  localparam int QDEPTH = 4;

  typedef struct packed {
    mssm_pkg::req_e req;
    logic [2:0]     sid;
    logic [31:0]    word;
  } req_item_t;

  typedef struct packed {
    mssm_pkg::kind_e kind;
    logic [31:0]     word;
    logic            last;
  } merge_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  multiway_sorted_set_merge_top DUT (.*);

  // model state
  logic [31:0] q_word [NSTR][QDEPTH];
  int          q_fill [NSTR];
  int          q_rd [NSTR];
  logic [7:0]  closed_m;
  logic        finished_m;
  logic [1:0]  mode_m;
  logic [7:0]  enable_m;

  req_item_t  pending_q[$];
  merge_out_t expected_q[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         drv_busy = 0;

  function automatic void clear_merge_state();
    for (int i = 0; i < NSTR; i++) begin
      q_fill[i] = 0;
      q_rd[i] = 0;
    end
    closed_m = '0;
    finished_m = 1'b0;
  endfunction

  function automatic void add_result(mssm_pkg::kind_e k, logic [31:0] w);
    merge_out_t r;
    r.kind = k;
    r.word = w;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_merge(req_item_t it);
    int   n0;
    logic [7:0] empty, exhausted, active, first, has_min;
    logic [31:0] min_w;
    logic done, have, emit;
    n0 = expected_q.size();
    case (it.req)
      mssm_pkg::REQ_PUSH: begin
        if (!closed_m[it.sid]) begin
          if (q_fill[it.sid] >= QDEPTH) add_result(mssm_pkg::KIND_DROP, '0);
          else begin
            q_word[it.sid][(q_rd[it.sid] + q_fill[it.sid]) % QDEPTH] = it.word;
            q_fill[it.sid]++;
          end
        end
      end
      mssm_pkg::REQ_CLOSE: closed_m[it.sid] = 1'b1;
      mssm_pkg::REQ_RESTART: clear_merge_state();
      default: ;
    endcase
    while (!finished_m) begin
      empty = '0;
      for (int i = 0; i < NSTR; i++) if (q_fill[i] == 0) empty[i] = 1'b1;
      exhausted = enable_m & closed_m & empty;
      active = enable_m & ~exhausted;
      first = enable_m & (~enable_m + 8'd1);
      if (mode_m == mssm_pkg::MODE_INTER) done = active == 0 || active != enable_m;
      else if (mode_m == mssm_pkg::MODE_DIFF)
        done = first == 0 || (exhausted & first) != 0;
      else done = active == 0;
      if (done) begin
        finished_m = 1'b1;
        add_result(mssm_pkg::KIND_FINISH, '0);
        break;
      end
      if ((active & ~closed_m & empty) != 0) break;
      have = 1'b0;
      min_w = '0;
      has_min = '0;
      for (int i = 0; i < NSTR; i++) begin
        if (active[i]) begin
          if (!have || q_word[i][q_rd[i]] < min_w) begin
            have = 1'b1;
            min_w = q_word[i][q_rd[i]];
            has_min = 8'd1 << i;
          end else if (q_word[i][q_rd[i]] == min_w) has_min[i] = 1'b1;
        end
      end
      for (int i = 0; i < NSTR; i++) begin
        if (has_min[i]) begin
          q_rd[i] = (q_rd[i] + 1) % QDEPTH;
          q_fill[i]--;
        end
      end
      if (mode_m == mssm_pkg::MODE_INTER) emit = has_min == enable_m;
      else if (mode_m == mssm_pkg::MODE_DIFF) emit = has_min == first;
      else emit = 1'b1;
      if (emit) add_result(mssm_pkg::KIND_WORD, min_w);
    end
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  initial forever #5 clk_i = ~clk_i;

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_merge(pending_q.pop_front());
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_q[0].req;
        s_axis_tdata <= {5'b0, pending_q[0].word, pending_q[0].sid};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    merge_out_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: kind %0d word %h last %0b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.kind != m_axis_tuser || exp_r.word != m_axis_tdata ||
            exp_r.last != m_axis_tlast) begin
          $display("%0t mismatch: expected kind %0d word %h last %0b, got kind %0d word %h last %0b",
                   $time, exp_r.kind, exp_r.word, exp_r.last, m_axis_tuser,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  function automatic req_item_t mk(mssm_pkg::req_e r, int s, logic [31:0] w);
    req_item_t it;
    it.req = r;
    it.sid = s[2:0];
    it.word = w;
    return it;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mssm_pkg::CFG_MODE) mode_m = val[1:0];
    else enable_m = val;
  endtask

  // well-formed merge with random ascending words; some noise
  task automatic queue_merge_batch(int n_words, bit noisy);
    logic [31:0] base [NSTR];
    int pushed [NSTR];
    int s;
    for (int i = 0; i < NSTR; i++) begin
      base[i] = $urandom_range(15);
      pushed[i] = 0;
    end
    pending_q.push_back(mk(mssm_pkg::REQ_RESTART, 0, '0));
    for (int k = 0; k < n_words; k++) begin
      s = $urandom_range(NSTR - 1);
      if (noisy && $urandom_range(9) == 0)
        pending_q.push_back(mk(mssm_pkg::req_e'($urandom_range(3)), s, $urandom));
      else if (pushed[s] < 6) begin
        base[s] = base[s] + $urandom_range(3);
        if ($urandom_range(15) == 0) base[s] = base[s] | 32'hFFFF_FFF0;
        pending_q.push_back(mk(mssm_pkg::REQ_PUSH, s, base[s]));
        pushed[s]++;
      end
    end
    for (int i = 0; i < NSTR; i++) pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, i, '0));
  endtask

  initial begin
    int cnt;
    clear_merge_state();
    mode_m = mssm_pkg::MODE_UNION;
    enable_m = 8'd1;
    for (int i = 0; i < NSTR; i++)
      for (int j = 0; j < QDEPTH; j++) q_word[i][j] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: two-stream union, full queue drop, extreme words, then intersection, difference and no enabled streams
    write_cfg(mssm_pkg::CFG_ENABLE, 8'h03);
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h0));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h5));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h6));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'h5));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'hAAAA_5555));
    pending_q.push_back(mk(mssm_pkg::REQ_NOP, 7, 32'h5555_AAAA));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 1, '0));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 1, '0));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'h9));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 0, '0));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 5, 32'h1));
    pending_q.push_back(mk(mssm_pkg::REQ_RESTART, 0, '0));
    drain();
    write_cfg(mssm_pkg::CFG_MODE, 8'(mssm_pkg::MODE_INTER));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h2));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'h2));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h3));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'h4));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 0, '0));
    drain();
    write_cfg(mssm_pkg::CFG_MODE, 8'(mssm_pkg::MODE_DIFF));
    pending_q.push_back(mk(mssm_pkg::REQ_RESTART, 0, '0));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h1));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 1, 32'h1));
    pending_q.push_back(mk(mssm_pkg::REQ_PUSH, 0, 32'h7));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 1, '0));
    pending_q.push_back(mk(mssm_pkg::REQ_CLOSE, 0, '0));
    drain();
    write_cfg(mssm_pkg::CFG_MODE, 8'd3);
    write_cfg(mssm_pkg::CFG_ENABLE, 8'h00);
    pending_q.push_back(mk(mssm_pkg::REQ_RESTART, 0, '0));
    drain();

    // random phases
    cnt = 0;
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      write_cfg(mssm_pkg::CFG_MODE, 8'(ph % 3));
      write_cfg(mssm_pkg::CFG_ENABLE, (ph == 0) ? 8'hFF : (ph == 1) ? 8'h80 :
                8'($urandom_range(1, 255)));
      for (int b = 0; b < 2; b++) queue_merge_batch($urandom_range(4, 14), ph % 2);
      drain();
      for (int k = 0; k < 4; k++)
        pending_q.push_back(mk(mssm_pkg::req_e'($urandom_range(3)), $urandom_range(7),
                               $urandom));
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
